### design/hce_pkg.sv
package hce_pkg;

    localparam int MAX_CODE_BITS = 63;
    localparam int DATA_BITS     = 57;
    localparam int CNT_W         = 6;
    localparam int PAR_W         = 6;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CNT_W-1:0] CODE_LENGTH_RST = CNT_W'(7);
    localparam logic [CNT_W-1:0] MSG_LENGTH_RST  = CNT_W'(4);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CODE_LENGTH = 1'b0,
        REG_MSG_LENGTH  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [CNT_W-1:0] code_length;
        logic [CNT_W-1:0] msg_length;
    } cfg_t;

    // After length resolution: raw chunk plus final codeword length
    typedef struct packed {
        logic [DATA_BITS-1:0] data_word;
        logic [CNT_W-1:0]     len;
    } place_t;

    // Data bits scattered onto codeword positions, parity slots zero
    typedef struct packed {
        logic [MAX_CODE_BITS-1:0] word;
        logic [CNT_W-1:0]         len;
    } spread_t;

    typedef struct packed {
        logic [MAX_CODE_BITS-1:0] word;
        logic [PAR_W-1:0]         parity;
        logic [CNT_W-1:0]         len;
    } sum_t;

    typedef struct packed {
        logic [MAX_CODE_BITS-1:0] codeword;
        logic [CNT_W-1:0]         code_count;
    } result_t;

    // Codeword position of the c-th data bit (1-based), 0 for c = 0
    function automatic logic [CNT_W-1:0] data_pos(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] p;
        if (c == '0)
            p = '0;
        else if (c <= CNT_W'(1))
            p = c + CNT_W'(2);
        else if (c <= CNT_W'(4))
            p = c + CNT_W'(3);
        else if (c <= CNT_W'(11))
            p = c + CNT_W'(4);
        else if (c <= CNT_W'(26))
            p = c + CNT_W'(5);
        else
            p = c + CNT_W'(6);
        return p;
    endfunction

    function automatic bit is_pow2(input int p);
        return (p != 0) && ((p & (p - 1)) == 0);
    endfunction

    // Data bit index held at non-power-of-two position p
    function automatic int data_index(input int p);
        int k;
        k = 0;
        for (int i = 0; i < PAR_W; i++)
        begin
            if ((1 << i) <= p)
                k = i;
        end
        return p - k - 2;
    endfunction

    // Positions whose number has bit i set
    function automatic logic [MAX_CODE_BITS-1:0] par_mask(input int i);
        logic [MAX_CODE_BITS-1:0] m;
        m = '0;
        for (int p = 1; p <= MAX_CODE_BITS; p++)
        begin
            m[p-1] = ((p >> i) & 1) != 0;
        end
        return m;
    endfunction

endpackage

### design/hce_if.sv
interface hce_in_if;
    import hce_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] data_word;
    logic [CNT_W-1:0]     data_count;

    modport source (output valid, output data_word, output data_count, input ready);
    modport sink   (input valid, input data_word, input data_count, output ready);
endinterface

interface hce_out_if;
    import hce_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MAX_CODE_BITS-1:0] codeword;
    logic [CNT_W-1:0]         code_count;

    modport source (output valid, output codeword, output code_count, input ready);
    modport sink   (input valid, input codeword, input code_count, output ready);
endinterface

### design/hamming_codeword_encoder_top.sv
// Hamming codeword encoder: each transaction on in_ch carries up to 57 message
// bits and a count of valid bits; each transaction on out_ch returns one
// codeword (bit 0 = position 1) and its length, with data bits in the
// non-power-of-two positions and parity bit i at position 2^i. The block
// takes one chunk per clock while out_ch is not stalled and returns its codeword
// through four register stages (length resolution, bit placement, parity XOR
// trees, parity insertion into the output register). in_ch.ready follows
// out_ch.ready combinationally through the stage valid bits, so empty stages
// fill even while the output waits. code_length and msg_length are written
// through cfg_we/cfg_index/cfg_wdata and reset to 7 and 4; write them only
// while no transaction is in flight.
module hamming_codeword_encoder_top (
    input  logic                          clk,
    input  logic                          rst_n,
    hce_in_if.sink                        in_ch,
    hce_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [hce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hce_pkg::CNT_W-1:0]     cfg_wdata
);
    import hce_pkg::*;

    // Configuration registers
    logic [CNT_W-1:0] code_length_reg;
    logic [CNT_W-1:0] msg_length_reg;
    cfg_t             cfg;

    // Stage-to-stage handshakes and payloads
    logic    s1_valid, s1_ready;
    logic    s2_valid, s2_ready;
    logic    s3_valid, s3_ready;
    place_t  s1_data;
    spread_t s2_data;
    sum_t    s3_data;
    result_t out_data;

    // Take a register write whenever the enable is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_length_reg <= CODE_LENGTH_RST;
            msg_length_reg  <= MSG_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CODE_LENGTH: code_length_reg <= cfg_wdata;
                REG_MSG_LENGTH:  msg_length_reg  <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        cfg.code_length = code_length_reg;
        cfg.msg_length  = msg_length_reg;
    end

    // Stage 1: clamp the count and fix the codeword length
    hce_len_stage u_len (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .data_word  (in_ch.data_word),
        .data_count (in_ch.data_count),
        .out_valid  (s1_valid),
        .out_ready  (s1_ready),
        .out_data   (s1_data)
    );

    // Stage 2: scatter data bits onto codeword positions
    hce_spread_stage u_spread (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // Stage 3: six parity XOR trees
    hce_parity_stage u_parity (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    // Stage 4: insert parity bits, hold the result for out_ch
    hce_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid),
        .in_ready  (s3_ready),
        .in_data   (s3_data),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_data)
    );

    assign out_ch.codeword   = out_data.codeword;
    assign out_ch.code_count = out_data.code_count;

endmodule

### design/hce_len_stage.sv
module hce_len_stage (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hce_pkg::cfg_t                  cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [hce_pkg::DATA_BITS-1:0]  data_word,
    input  logic [hce_pkg::CNT_W-1:0]      data_count,
    output logic                           out_valid,
    input  logic                           out_ready,
    output hce_pkg::place_t                out_data
);
    import hce_pkg::*;

    logic             valid_reg;
    place_t           data_reg;
    place_t           data_next;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] pos_last;

    // Clamp the bit count, then cut the codeword at the last data bit or at n
    always_comb
    begin
        count = data_count;
        if (count > cfg.msg_length)
            count = cfg.msg_length;
        if (count > CNT_W'(DATA_BITS))
            count = CNT_W'(DATA_BITS);
        pos_last            = data_pos(count);
        data_next.data_word = data_word;
        data_next.len       = (pos_last < cfg.code_length) ? pos_last : cfg.code_length;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

### design/hce_spread_stage.sv
module hce_spread_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  hce_pkg::place_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output hce_pkg::spread_t out_data
);
    import hce_pkg::*;

    logic                     valid_reg;
    spread_t                  data_reg;
    spread_t                  data_next;
    logic [MAX_CODE_BITS-1:0] word;

    // Fixed wiring: each non-power-of-two position takes its data bit,
    // dropped beyond the codeword length
    genvar p;
    generate
        for (p = 1; p <= MAX_CODE_BITS; p++)
        begin : g_pos
            if (is_pow2(p))
            begin : g_par
                assign word[p-1] = 1'b0;
            end
            else
            begin : g_dat
                assign word[p-1] = in_data.data_word[data_index(p)]
                                   & (CNT_W'(p) <= in_data.len);
            end
        end
    endgenerate

    always_comb
    begin
        data_next.word = word;
        data_next.len  = in_data.len;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

### design/hce_parity_stage.sv
module hce_parity_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  hce_pkg::spread_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output hce_pkg::sum_t    out_data
);
    import hce_pkg::*;

    logic valid_reg;
    sum_t data_reg;
    sum_t data_next;

    // Parity bit i: XOR of all set bits whose position has bit i set
    always_comb
    begin
        data_next.word = in_data.word;
        data_next.len  = in_data.len;
        for (int i = 0; i < PAR_W; i++)
        begin
            data_next.parity[i] = ^(in_data.word & par_mask(i));
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

### design/hce_out_stage.sv
module hce_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  hce_pkg::sum_t    in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output hce_pkg::result_t out_data
);
    import hce_pkg::*;

    logic    valid_reg;
    result_t data_reg;
    result_t data_next;

    // Insert parity bits, dropping those whose position lies past the codeword end
    always_comb
    begin
        data_next.codeword   = in_data.word;
        data_next.code_count = in_data.len;
        for (int i = 0; i < PAR_W; i++)
        begin
            if (CNT_W'(1 << i) <= in_data.len)
                data_next.codeword[(1 << i) - 1] = in_data.parity[i];
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

### design/hce_checker.sv
module hce_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [hce_pkg::MAX_CODE_BITS-1:0] codeword,
    input logic [hce_pkg::CNT_W-1:0]         code_count
);
    import hce_pkg::*;

    logic [PAR_W-1:0] syndrome;

    always_comb
    begin
        for (int i = 0; i < PAR_W; i++)
        begin
            syndrome[i] = ^(codeword & par_mask(i));
        end
    end

    // Every codeword, even a truncated one, checks clean
    a_syndrome_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> syndrome == '0)
        else $error("codeword syndrome not zero");

    a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (codeword >> code_count) == '0)
        else $error("codeword bits set beyond code_count");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(codeword) && $stable(code_count))
        else $error("stalled result changed or dropped");

    // With the output free-flowing, an accepted input must come out as a result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_valid && in_ready && rst_n, 4) && $past(out_ready && rst_n, 3)
            && $past(out_ready && rst_n, 2) && $past(out_ready && rst_n, 1)
        |-> out_valid)
        else $error("result missing four cycles after input");

endmodule

bind hamming_codeword_encoder_top hce_checker u_hce_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .codeword   (out_ch.codeword),
    .code_count (out_ch.code_count)
);
